FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// A same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  `ASSERT_ALWAYS(lbl, clk_s, rst_s, (ante) |-> (cons), msg)

// An implication checked in the next cycle.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  `ASSERT_ALWAYS(lbl, clk_s, rst_s, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/rocf_pkg.sv
// Shared types and codes of the rectangle canvas rasterizer.
// No dependencies; used by every RTL module of the block.
package rocf_pkg;

  // Fixed-point compare width; covers every legal MAX_SIDE and FRAC_BITS.
  localparam int CMP_W = 28;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_DRAW,
    CMD_READ,
    CMD_REPORT
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_RDWAIT,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    cmd_op_t                  op;
    logic                     filled;
    logic [7:0]               ch;
    logic [1:0]               status;
    logic [7:0]               read_row;
    logic [7:0]               read_col;
    logic signed [CMP_W-1:0]  xl;
    logic signed [CMP_W-1:0]  xr;
    logic signed [CMP_W-1:0]  xl1;
    logic signed [CMP_W-1:0]  xr1;
    logic signed [CMP_W-1:0]  yl;
    logic signed [CMP_W-1:0]  yr;
    logic signed [CMP_W-1:0]  yl1;
    logic signed [CMP_W-1:0]  yr1;
  } cmd_t;

endpackage

FILE: hw/rtl/rect_outline_fill_canvas.sv
// A read fetches its pixel through the memory read port; a rejected or
// unused request is answered without touching memory. A clear or draw
// sweeps width*height pixels, one pixel per cycle through the write port,
// and the back end takes one item at a time while a two-entry command
// queue keeps accepting while the sweep runs. Reset (synchronous, active
// low) restores the registers to 256, 256 and 32; canvas contents are kept.
module rect_outline_fill_canvas import rocf_pkg::*; #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rect_left, rect_top, rect_width, rect_height, filled, paint_char,
  // read_row, read_col (from bit 0 up)
  input  logic [103:0] in_tdata,
  // req_type
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_value
  output logic [7:0]   out_tdata,
  // status
  output logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int IDXW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic [8:0]    cfg_w_r;
  logic [8:0]    cfg_w_nxt;
  logic [8:0]    cfg_h_r;
  logic [8:0]    cfg_h_nxt;
  logic [7:0]    cfg_bg_r;
  logic [7:0]    cfg_bg_nxt;
  logic          cfg_wr;
  logic [SW-1:0] cw_lim;
  logic [SW-1:0] ch_lim;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  cmd_t          q_in;
  cmd_t          q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_w_nxt  = cfg_w_r;
    cfg_h_nxt  = cfg_h_r;
    cfg_bg_nxt = cfg_bg_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_w_nxt  = pwdata[8:0];
        REG_HEIGHT: cfg_h_nxt  = pwdata[8:0];
        REG_BG:     cfg_bg_nxt = pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {23'd0, cfg_w_r};
      REG_HEIGHT: prdata = {23'd0, cfg_h_r};
      REG_BG:     prdata = {24'd0, cfg_bg_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= 9'd256;
      cfg_h_r  <= 9'd256;
      cfg_bg_r <= 8'd32;
    end else begin
      cfg_w_r  <= cfg_w_nxt;
      cfg_h_r  <= cfg_h_nxt;
      cfg_bg_r <= cfg_bg_nxt;
    end
  end

  always_comb begin
    if (cfg_w_r == 9'd0) begin
      cw_lim = SW'(1);
    end else if (32'(cfg_w_r) > MAX_SIDE) begin
      cw_lim = SW'(MAX_SIDE);
    end else begin
      cw_lim = SW'(cfg_w_r);
    end
    if (cfg_h_r == 9'd0) begin
      ch_lim = SW'(1);
    end else if (32'(cfg_h_r) > MAX_SIDE) begin
      ch_lim = SW'(MAX_SIDE);
    end else begin
      ch_lim = SW'(cfg_h_r);
    end
  end

  rocf_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cw_lim    (cw_lim),
    .ch_lim    (ch_lim),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  rocf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rocf_back #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW),
    .IDXW      (IDXW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!q_empty),
    .cmd        (q_head),
    .cmd_pop    (q_pop),
    .cw_lim     (cw_lim),
    .ch_lim     (ch_lim),
    .bg_char    (cfg_bg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hw/rtl/rocf_front.sv
// Front end: accepts input transactions and turns each into a command.
// Depends on rocf_pkg.
module rocf_front import rocf_pkg::*; #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8,
  parameter int SW        = $clog2(MAX_SIDE + 1)
) (
  input  logic          in_tvalid,
  output logic          in_tready,
  // rect_left, rect_top, rect_width, rect_height, filled, paint_char,
  // read_row, read_col (from bit 0 up)
  input  logic [103:0]  in_tdata,
  // req_type
  input  logic [1:0]    in_tuser,
  input  logic [SW-1:0] cw_lim,
  input  logic [SW-1:0] ch_lim,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_data
);

  logic signed [19:0]      rect_left;
  logic signed [19:0]      rect_top;
  logic [18:0]             rect_width;
  logic [18:0]             rect_height;
  logic [7:0]              read_row;
  logic [7:0]              read_col;
  logic signed [CMP_W-1:0] x;
  logic signed [CMP_W-1:0] y;
  logic signed [CMP_W-1:0] w;
  logic signed [CMP_W-1:0] h;
  logic signed [CMP_W-1:0] one;

  assign rect_left   = in_tdata[19:0];
  assign rect_top    = in_tdata[39:20];
  assign rect_width  = in_tdata[58:40];
  assign rect_height = in_tdata[77:59];
  assign read_row    = in_tdata[94:87];
  assign read_col    = in_tdata[102:95];

  assign x   = CMP_W'(rect_left);
  assign y   = CMP_W'(rect_top);
  assign w   = signed'(CMP_W'(rect_width));
  assign h   = signed'(CMP_W'(rect_height));
  assign one = signed'({{(CMP_W-1){1'b0}}, 1'b1} << FRAC_BITS);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data          = '0;
    q_data.filled   = in_tdata[78];
    q_data.ch       = in_tdata[86:79];
    q_data.read_row = read_row;
    q_data.read_col = read_col;
    q_data.xl       = x;
    q_data.xr       = x + w;
    q_data.xl1      = x + one;
    q_data.xr1      = x + w - one;
    q_data.yl       = y;
    q_data.yr       = y + h;
    q_data.yl1      = y + one;
    q_data.yr1      = y + h - one;
    q_data.status   = ST_DONE;
    case (in_tuser)
      REQ_CLEAR: begin
        q_data.op = CMD_CLEAR;
      end
      REQ_DRAW: begin
        if (rect_width == '0 || rect_height == '0) begin
          q_data.op     = CMD_REPORT;
          q_data.status = ST_REJECT;
        end else begin
          q_data.op = CMD_DRAW;
        end
      end
      REQ_READ: begin
        if (32'(read_row) >= 32'(ch_lim) || 32'(read_col) >= 32'(cw_lim)) begin
          q_data.op     = CMD_REPORT;
          q_data.status = ST_RANGE;
        end else begin
          q_data.op = CMD_READ;
        end
      end
      default: begin
        q_data.op = CMD_REPORT;
      end
    endcase
  end

endmodule

FILE: hw/rtl/rocf_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on rocf_pkg for the command type.
module rocf_queue import rocf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       wp_nxt;
  logic       rp_r;
  logic       rp_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/rocf_back.sv
// Back end: sweeps the canvas memory for clears and draws, reads pixels
// and holds the result register. Depends on rocf_pkg.
module rocf_back import rocf_pkg::*; #(
  parameter int MAX_SIDE  = 256,
  parameter int FRAC_BITS = 8,
  parameter int SW        = $clog2(MAX_SIDE + 1),
  parameter int IDXW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  cmd_t          cmd,
  output logic          cmd_pop,
  input  logic [SW-1:0] cw_lim,
  input  logic [SW-1:0] ch_lim,
  input  logic [7:0]    bg_char,
  output logic          out_tvalid,
  input  logic          out_tready,
  // pixel_value
  output logic [7:0]    out_tdata,
  // status
  output logic [1:0]    out_tuser
);

  localparam int DEPTH = 2 ** (2 * IDXW);

  logic [7:0]              mem [DEPTH];
  logic [7:0]              rd_q;
  logic                    mem_we;
  logic [2*IDXW-1:0]       mem_waddr;
  logic [7:0]              mem_wdata;
  logic                    mem_re;
  logic [2*IDXW-1:0]       mem_raddr;

  bk_state_t               state_r;
  bk_state_t               state_nxt;
  cmd_t                    cmd_r;
  cmd_t                    cmd_nxt;
  logic [IDXW-1:0]         row_r;
  logic [IDXW-1:0]         row_nxt;
  logic [IDXW-1:0]         col_r;
  logic [IDXW-1:0]         col_nxt;
  logic [7:0]              res_pix_r;
  logic [7:0]              res_pix_nxt;
  logic [1:0]              res_st_r;
  logic [1:0]              res_st_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [7:0]              out_pix_r;
  logic [7:0]              out_pix_nxt;
  logic [1:0]              out_st_r;
  logic [1:0]              out_st_nxt;

  logic [IDXW-1:0]         cw_last;
  logic [IDXW-1:0]         ch_last;
  logic signed [CMP_W-1:0] px;
  logic signed [CMP_W-1:0] py;
  logic signed [CMP_W-1:0] xl;
  logic signed [CMP_W-1:0] xr;
  logic signed [CMP_W-1:0] xl1;
  logic signed [CMP_W-1:0] xr1;
  logic signed [CMP_W-1:0] yl;
  logic signed [CMP_W-1:0] yr;
  logic signed [CMP_W-1:0] yl1;
  logic signed [CMP_W-1:0] yr1;
  logic                    covered;
  logic                    on_edge;

  assign cw_last = IDXW'(cw_lim - SW'(1));
  assign ch_last = IDXW'(ch_lim - SW'(1));

  assign px  = signed'(CMP_W'(col_r) << FRAC_BITS);
  assign py  = signed'(CMP_W'(row_r) << FRAC_BITS);
  assign xl  = cmd_r.xl;
  assign xr  = cmd_r.xr;
  assign xl1 = cmd_r.xl1;
  assign xr1 = cmd_r.xr1;
  assign yl  = cmd_r.yl;
  assign yr  = cmd_r.yr;
  assign yl1 = cmd_r.yl1;
  assign yr1 = cmd_r.yr1;

  assign covered = (py >= yl) && (px >= xl) && (py <= yr) && (px <= xr);
  assign on_edge = (px < xl1) || (px > xr1) || (py < yl1) || (py > yr1);

  assign mem_waddr = {row_r, col_r};
  assign mem_raddr = {IDXW'(cmd.read_row), IDXW'(cmd.read_col)};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    res_pix_nxt   = res_pix_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pix_nxt   = out_pix_r;
    out_st_nxt    = out_st_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = bg_char;
    mem_re        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          cmd_nxt     = cmd;
          row_nxt     = '0;
          col_nxt     = '0;
          res_pix_nxt = 8'd0;
          res_st_nxt  = cmd.status;
          case (cmd.op)
            CMD_CLEAR, CMD_DRAW: begin
              state_nxt = BK_SWEEP;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              state_nxt = BK_RDWAIT;
            end
            default: begin
              state_nxt = BK_DONE;
            end
          endcase
        end
      end
      BK_SWEEP: begin
        if (cmd_r.op == CMD_CLEAR) begin
          mem_we = 1'b1;
        end else begin
          mem_we    = covered && (cmd_r.filled || on_edge);
          mem_wdata = cmd_r.ch;
        end
        if (col_r == cw_last) begin
          col_nxt = '0;
          row_nxt = row_r + IDXW'(1);
          if (row_r == ch_last) begin
            state_nxt = BK_DONE;
          end
        end else begin
          col_nxt = col_r + IDXW'(1);
        end
      end
      BK_RDWAIT: begin
        res_pix_nxt = rd_q;
        state_nxt   = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = res_pix_r;
          out_st_nxt    = res_st_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    res_pix_r <= res_pix_nxt;
    res_st_r  <= res_st_nxt;
    out_pix_r <= out_pix_nxt;
    out_st_r  <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

FILE: hw/rtl/rocf_checker.sv
// Port-level checks of the rectangle canvas rasterizer, bound to the top.
// Depends on assert_macros.svh and rocf_pkg.
`include "assert_macros.svh"

module rocf_checker import rocf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pend_r;
  logic [2:0] pend_nxt;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign pend_nxt = pend_r + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result transaction changed")
  `ASSERT_IMPLIES(a_status_legal, clk, rst_n, out_tvalid, out_tuser == ST_DONE || out_tuser == ST_REJECT || out_tuser == ST_RANGE, "illegal status code")
  `ASSERT_IMPLIES(a_status_pixel, clk, rst_n, out_tvalid && out_tuser != ST_DONE, out_tdata == 8'd0, "failed item carries a pixel value")
  `ASSERT_IMPLIES(a_no_orphan, clk, rst_n, out_tvalid, pend_r != 3'd0, "result without an accepted item")
  `ASSERT_ALWAYS(a_pend_bound, clk, rst_n, pend_r <= 3'd4, "more items in flight than the block can hold")

endmodule

bind rect_outline_fill_canvas rocf_checker u_rocf_checker (.*);

FILE: tb/tb_rect_outline_fill_canvas.sv
// Self-checking testbench for the rectangle fill and outline canvas rasterizer.
// Depends on rocf_pkg and rect_outline_fill_canvas; drives stream and APB ports.
`timescale 1ns / 1ps

module tb_rect_outline_fill_canvas;
  import rocf_pkg::*;

  localparam int          SIDE_MAX  = 256;
  localparam longint      ONE       = 256;
  localparam logic [1:0]  REQ_SPARE = 2'd3;
  localparam int          PHASES    = 7;
  localparam int          PHASE_ITEMS = 11;
  localparam logic [PHASES-1:0][8:0] PH_WIDTH  =
    {9'd16, 9'd1, 9'd256, 9'd5, 9'd9, 9'd0, 9'd3};
  localparam logic [PHASES-1:0][8:0] PH_HEIGHT =
    {9'd8, 9'd1, 9'd3, 9'd256, 9'd13, 9'd0, 9'd16};
  localparam logic [PHASES-1:0][7:0] PH_BG     =
    {8'h41, 8'hFF, 8'h00, 8'h80, 8'h2E, 8'h01, 8'h5A};

  typedef struct packed {
    logic [1:0]         req;
    logic signed [19:0] left;
    logic signed [19:0] top;
    logic [18:0]        wid;
    logic [18:0]        hgt;
    logic               fill;
    logic [7:0]         ch;
    logic [7:0]         row;
    logic [7:0]         col;
  } canvas_req_t;

  typedef struct packed {
    logic [7:0] pix;
    logic [1:0] st;
  } canvas_resp_t;

  typedef struct packed {
    bit           is_cfg;
    logic [1:0]   reg_idx;
    logic [31:0]  reg_val;
    canvas_req_t  rq;
    bit           chk;
    canvas_resp_t resp;
  } stim_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic [1:0]   out_tuser;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  logic [7:0]   canvas_px [0:SIDE_MAX*SIDE_MAX-1];
  logic [8:0]   cur_width;
  logic [8:0]   cur_height;
  logic [7:0]   cur_bg;

  canvas_resp_t awaited_q [$];
  stim_row_t    stim_tab [$];
  int           mismatch_count;
  bit           tx_calm;
  bit           rx_calm;

  rect_outline_fill_canvas dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned side_of(input logic [8:0] v);
    if (v < 1) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return 32'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one request to the shadow canvas and returns the result it gives.
  task automatic canvas_apply(input canvas_req_t rq, output canvas_resp_t resp);
    int unsigned cw;
    int unsigned chh;
    longint x, y, w, h, px, py;
    bit edge_hit;
    cw = side_of(cur_width);
    chh = side_of(cur_height);
    resp.pix = 8'd0;
    resp.st = ST_DONE;
    case (rq.req)
      REQ_CLEAR: begin
        for (int i = 0; i < chh; i++)
          for (int j = 0; j < cw; j++)
            canvas_px[i*SIDE_MAX+j] = cur_bg;
      end
      REQ_DRAW: begin
        x = {{44{rq.left[19]}}, rq.left};
        y = {{44{rq.top[19]}}, rq.top};
        w = {45'd0, rq.wid};
        h = {45'd0, rq.hgt};
        if (w == 0 || h == 0) begin
          resp.st = ST_REJECT;
        end else begin
          for (int i = 0; i < chh; i++) begin
            py = longint'(i) * ONE;
            for (int j = 0; j < cw; j++) begin
              px = longint'(j) * ONE;
              if (py >= y && px >= x && py <= y + h && px <= x + w) begin
                edge_hit = (px - x < ONE) || (x + w - px < ONE) ||
                           (py - y < ONE) || (y + h - py < ONE);
                if (rq.fill || edge_hit) canvas_px[i*SIDE_MAX+j] = rq.ch;
              end
            end
          end
        end
      end
      REQ_READ: begin
        if (rq.row >= chh || rq.col >= cw) resp.st = ST_RANGE;
        else resp.pix = canvas_px[int'(rq.row)*SIDE_MAX + int'(rq.col)];
      end
      default: ;
    endcase
  endtask

  function automatic void tab_item(input logic [1:0] req, input int left, input int top,
                                   input int wid, input int hgt, input bit fill,
                                   input int ch, input int row, input int col,
                                   input bit chk, input int pix, input logic [1:0] st);
    stim_row_t r;
    r = '0;
    r.rq.req = req;
    r.rq.left = left[19:0];
    r.rq.top = top[19:0];
    r.rq.wid = wid[18:0];
    r.rq.hgt = hgt[18:0];
    r.rq.fill = fill;
    r.rq.ch = ch[7:0];
    r.rq.row = row[7:0];
    r.rq.col = col[7:0];
    r.chk = chk;
    r.resp.pix = pix[7:0];
    r.resp.st = st;
    stim_tab.push_back(r);
  endfunction

  function automatic void tab_cfg(input logic [1:0] idx, input int val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_tab.push_back(r);
  endfunction

  function automatic canvas_req_t rand_req(input int unsigned cw, input int unsigned chh);
    canvas_req_t rq;
    int unsigned pick;
    rq.left = 20'($urandom);
    rq.top = 20'($urandom);
    rq.wid = 19'($urandom);
    rq.hgt = 19'($urandom);
    rq.fill = 1'($urandom);
    rq.ch = 8'($urandom);
    rq.row = 8'($urandom);
    rq.col = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 12) rq.req = REQ_CLEAR;
    else if (pick < 58) rq.req = REQ_DRAW;
    else if (pick < 94) rq.req = REQ_READ;
    else rq.req = REQ_SPARE;
    if (rq.req == REQ_DRAW && $urandom_range(0, 9) != 0) begin
      rq.left = 20'($urandom_range(0, (cw + 4) * 256) - 512);
      rq.top = 20'($urandom_range(0, (chh + 4) * 256) - 512);
      rq.wid = 19'($urandom_range(1, (cw + 1) * 256));
      rq.hgt = 19'($urandom_range(1, (chh + 1) * 256));
      if ($urandom_range(0, 11) == 0) rq.wid = '0;
      if ($urandom_range(0, 11) == 0) rq.hgt = '0;
    end
    if (rq.req == REQ_READ && $urandom_range(0, 4) != 0) begin
      rq.row = 8'($urandom_range(0, chh - 1));
      rq.col = 8'($urandom_range(0, cw - 1));
    end
    return rq;
  endfunction

  task automatic issue_req(input canvas_req_t rq, input bit chk, input canvas_resp_t typed);
    int unsigned gap;
    canvas_resp_t got;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= rq.req;
    in_tdata <= {1'b0, rq.col, rq.row, rq.ch, rq.fill, rq.hgt, rq.wid, rq.top, rq.left};
    do @(posedge clk); while (!in_tready);
    canvas_apply(rq, got);
    awaited_q.push_back(chk ? typed : got);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cur_width = val[8:0];
      REG_HEIGHT: cur_height = val[8:0];
      REG_BG:     cur_bg = val[7:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : check_results
    canvas_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_q.size() == 0) begin
        report_mismatch($sformatf("result pixel %0h status %0d with none awaited",
                                  out_tdata, out_tuser));
      end else begin
        want = awaited_q.pop_front();
        if (out_tdata !== want.pix)
          report_mismatch($sformatf("pixel %0h, wanted %0h", out_tdata, want.pix));
        if (out_tuser !== want.st)
          report_mismatch($sformatf("status %0d, wanted %0d", out_tuser, want.st));
      end
    end
  end

  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    canvas_resp_t none;
    none = '0;
    mismatch_count = 0;
    cur_width = 9'd256;
    cur_height = 9'd256;
    cur_bg = 8'd32;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // Full 256 by 256 canvas: a draw before any clear paints every pixel.
    tab_item(REQ_DRAW, -256, -256, 76800, 76800, 1, "R", 0, 0, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 255, 1, "R", ST_DONE);
    tab_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32, ST_DONE);
    tab_item(REQ_DRAW, 640, 256, 2560, 1344, 0, "r", 0, 0, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 3, 3, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 3, 5, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 6, 12, 0, 0, ST_DONE);
    tab_item(REQ_DRAW, 0, 0, 0, 1280, 1, "x", 0, 0, 1, 0, ST_REJECT);
    tab_item(REQ_DRAW, 524287, -524288, 1, 0, 1, "x", 0, 0, 1, 0, ST_REJECT);
    tab_item(REQ_DRAW, 0, 0, 0, 0, 0, "x", 0, 0, 1, 0, ST_REJECT);
    tab_item(REQ_SPARE, 0, 0, 0, 0, 0, 0, 7, 7, 1, 0, ST_DONE);
    // Oversized width register clamps to 256 columns, zero height to one row.
    tab_cfg(REG_WIDTH, 511);
    tab_cfg(REG_HEIGHT, 0);
    tab_cfg(REG_BG, 0);
    tab_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 255, 1, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, ST_RANGE);
    tab_item(REQ_DRAW, -524288, -524288, 524287, 524287, 1, 8'hAA, 0, 0, 0, 0, ST_DONE);
    tab_item(REQ_DRAW, 0, 0, 524287, 524287, 0, 8'hFF, 0, 0, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 128, 0, 0, ST_DONE);
    tab_cfg(REG_WIDTH, 0);
    tab_cfg(REG_HEIGHT, 300);
    tab_cfg(REG_BG, 255);
    tab_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 0, 1, 255, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, ST_RANGE);
    tab_item(REQ_DRAW, -128, 25728, 128, 256, 0, 0, 0, 0, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 101, 0, 0, 0, ST_DONE);
    tab_item(REQ_READ, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0, ST_DONE);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_tab[r]) begin
      if (stim_tab[r].is_cfg) begin
        drain_results();
        write_reg(stim_tab[r].reg_idx, stim_tab[r].reg_val);
      end else begin
        issue_req(stim_tab[r].rq, stim_tab[r].chk, stim_tab[r].resp);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(REG_WIDTH, 32'(PH_WIDTH[ph]));
      write_reg(REG_HEIGHT, 32'(PH_HEIGHT[ph]));
      write_reg(REG_BG, 32'(PH_BG[ph]));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++)
        issue_req(rand_req(side_of(cur_width), side_of(cur_height)), 1'b0, none);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
